// File: hw/rtl/keyword_substitution_cipher_assert.svh
// ----------------------------------------------------------------------------
// keyword substitution cipher assertion macros
// shared concurrent assertion forms, clocked on clock and gated by reset
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// plain property, checked outside reset
`define KWSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// same-cycle implication, checked outside reset
`define KWSC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// types and constants shared by the keyword substitution cipher modules
// ----------------------------------------------------------------------------
package kwsc_pkg;

   localparam int NumLetters = 26;
   localparam int KeyBytes   = 24;
   localparam int MaxKey     = 24;

   typedef logic [4:0] letter_type;
   typedef logic [7:0] char_type;

   // table write port from the rebuild sequencer
   typedef struct packed {
      logic       en;
      letter_type plain;
      letter_type cipher;
   } tbl_wr_type;

   localparam logic [1:0] CsrKeyLow    = 2'd0;
   localparam logic [1:0] CsrKeyMid    = 2'd1;
   localparam logic [1:0] CsrKeyHigh   = 2'd2;
   localparam logic [1:0] CsrKeyLength = 2'd3;

   localparam char_type CharLowerA = 8'h61;
   localparam char_type CharLowerZ = 8'h7a;
   localparam char_type CharUpperA = 8'h41;
   localparam char_type CharUpperZ = 8'h5a;

   localparam letter_type LastLetter = 5'd25;
   localparam letter_type CountFull  = 5'd26;

   localparam logic [63:0] KeyLowReset    = 64'd127979059635571;
   localparam logic [4:0]  KeyLengthReset = 5'd6;

endpackage

// File: hw/rtl/kwsc_table_build.sv
// ----------------------------------------------------------------------------
// kwsc_table_build
// rebuild sequencer: walks the keyword, then the unused letters, and writes
// one forward / inverse table entry pair per new cipher alphabet letter
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_assert.svh"

module kwsc_table_build
   import kwsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [8*KeyBytes-1:0]   key_bytes,
   input  logic [4:0]              key_length,
   output logic                    busy,
   output tbl_wr_type              tbl_wr
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StKey  = 2'd1;
   localparam logic [1:0] StFill = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [4:0]                 pos_ff, pos_in;
   letter_type                 count_ff, count_in;
   logic [NumLetters-1:0]      used_ff, used_in;
   logic [KeyBytes-1:0][7:0]   key_arr;
   logic [4:0]                 key_len;
   char_type                   key_byte;
   logic                       key_lower, key_upper, key_letter;
   char_type                   key_off;
   letter_type                 key_idx;
   letter_type                 sel_idx;
   logic                       used_hit;

   assign key_arr  = key_bytes;
   assign key_len  = (key_length > 5'(MaxKey)) ? 5'(MaxKey) : key_length;
   assign key_byte = (pos_ff < 5'(KeyBytes)) ? key_arr[pos_ff] : '0;

   // lowercase first, then letter index
   assign key_lower  = (key_byte >= CharLowerA) && (key_byte <= CharLowerZ);
   assign key_upper  = (key_byte >= CharUpperA) && (key_byte <= CharUpperZ);
   assign key_letter = key_lower || key_upper;
   assign key_off    = key_lower ? (key_byte - CharLowerA) :
                       key_upper ? (key_byte - CharUpperA) : '0;
   assign key_idx    = key_off[4:0];

   assign sel_idx  = (state_ff == StFill) ? pos_ff : key_idx;
   assign used_hit = used_ff[sel_idx];
   assign busy     = (state_ff != StIdle);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      used_in  = used_ff;
      tbl_wr   = '0;
      case (state_ff)
         StKey: begin
            if (pos_ff < key_len) begin
               pos_in = pos_ff + 5'd1;
               if (key_letter && !used_hit) begin
                  used_in[sel_idx] = 1'b1;
                  tbl_wr.en        = 1'b1;
                  tbl_wr.plain     = count_ff;
                  tbl_wr.cipher    = key_idx;
                  count_in         = count_ff + 5'd1;
               end
            end else begin
               state_in = StFill;
               pos_in   = '0;
            end
         end
         StFill: begin
            if (!used_hit) begin
               used_in[sel_idx] = 1'b1;
               tbl_wr.en        = 1'b1;
               tbl_wr.plain     = count_ff;
               tbl_wr.cipher    = pos_ff;
               count_in         = count_ff + 5'd1;
            end
            if (pos_ff == LastLetter) begin
               state_in = StIdle;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= StKey;
         pos_ff   <= '0;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   `KWSC_ASSERT(a_count_bound, (count_ff <= CountFull), "cipher alphabet count overflow")
   `KWSC_ASSERT_IMPL(a_idle_full, (state_ff == StIdle), (count_ff == CountFull), "rebuild ended with alphabet incomplete")
   `KWSC_ASSERT_IMPL(a_wr_range, tbl_wr.en, ((tbl_wr.plain <= LastLetter) && (tbl_wr.cipher <= LastLetter)), "table write address out of range")

endmodule

// File: hw/rtl/kwsc_lookup.sv
// ----------------------------------------------------------------------------
// kwsc_lookup
// forward and inverse table memories with a two-stage read pipeline
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_assert.svh"

module kwsc_lookup
   import kwsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        busy,
   input  tbl_wr_type  tbl_wr,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  char_type    req_in_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output char_type    rsp_out_char
);

   letter_type fwd_mem [NumLetters];
   letter_type inv_mem [NumLetters];

   logic       accept;
   logic       s1_advance;
   logic       req_letter;
   char_type   char_off;
   letter_type rd_addr;
   letter_type mapped;

   logic       s1_valid_ff, s1_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   letter_type fwd_rd_ff, inv_rd_ff;
   logic       mode_ff;
   logic       letter_ff;
   char_type   out_char_ff;

   assign req_letter = (req_in_char >= CharLowerA) && (req_in_char <= CharLowerZ);
   assign char_off   = req_letter ? (req_in_char - CharLowerA) : '0;
   assign rd_addr    = char_off[4:0];

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy || (s1_valid_ff && !s1_advance);
   assign accept     = req_valid && !req_stall;

   // table writes from the rebuild sequencer
   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         fwd_mem[tbl_wr.plain]  <= tbl_wr.cipher;
         inv_mem[tbl_wr.cipher] <= tbl_wr.plain;
      end
   end

   // synchronous read, held while the stage is stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_rd_ff <= fwd_mem[rd_addr];
         inv_rd_ff <= inv_mem[rd_addr];
         mode_ff   <= req_mode;
         letter_ff <= req_letter;
      end
   end

   assign mapped = mode_ff ? inv_rd_ff : fwd_rd_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = s1_valid_ff;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_char_ff <= letter_ff ? (CharLowerA + {3'b000, mapped}) : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;

   `KWSC_ASSERT(a_no_read_in_build, !(accept && tbl_wr.en), "transaction accepted during table rebuild")
   `KWSC_ASSERT(a_accept_fills_s1, (accept |=> s1_valid_ff), "accepted transaction lost in read stage")
   `KWSC_ASSERT(a_s1_hold, ((s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(fwd_rd_ff) && $stable(inv_rd_ff) && $stable(mode_ff))), "read stage changed while stalled")

endmodule

// File: hw/rtl/keyword_substitution_cipher.sv
// a request is registered in the read stage, then its result in the output register
// throughput: one transaction per cycle when not stalled, reading both tables
// tables rebuild after reset and after every csr write, with req_stall
// high throughout
// reset loads keyword "secret" with length 6
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// keyword substitution cipher on lowercase ascii letters, encrypt or decrypt
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
   import kwsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_in_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] key_low_ff;
   logic [63:0] key_mid_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        build_busy;
   logic        busy;
   tbl_wr_type  tbl_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= KeyLowReset;
         key_mid_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= KeyLengthReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrKeyLow:    key_low_ff    <= csr_write_data;
            CsrKeyMid:    key_mid_ff    <= csr_write_data;
            CsrKeyHigh:   key_high_ff   <= csr_write_data;
            CsrKeyLength: key_length_ff <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   assign busy = build_busy || csr_write_enable;

   kwsc_table_build u_build (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_write_enable),
      .key_bytes  ({key_high_ff, key_mid_ff, key_low_ff}),
      .key_length (key_length_ff),
      .busy       (build_busy),
      .tbl_wr     (tbl_wr)
   );

   kwsc_lookup u_lookup (
      .clock        (clock),
      .reset        (reset),
      .busy         (busy),
      .tbl_wr       (tbl_wr),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the keyword substitution cipher: a table of
// directed transactions after reset, then random traffic over a series of
// keywords, each result checked against a pinned value or a table-driven predictor
// ----------------------------------------------------------------------------
module tb;
   import kwsc_pkg::*;

   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;
   localparam int   QuietLimit  = 3000;
   localparam int   HoldOffCycles = 300;

   typedef struct {
      logic     mode;
      char_type in_char;
      bit       known;
      char_type out_char;
   } stim_row_type;

   typedef struct {
      bit       known;
      char_type value;
   } pinned_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [7:0]  req_in_char;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_char;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   // predictor copy of the keyword registers and both lookup tables
   logic [63:0] key_word_low;
   logic [63:0] key_word_mid;
   logic [63:0] key_word_high;
   logic [4:0]  key_len;
   letter_type  plain_to_cipher [NumLetters];
   letter_type  cipher_to_plain [NumLetters];

   char_type    pending_out_chars [$];
   pinned_type  pinned_out_chars [$];
   pinned_type  pin;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;

   // after reset the keyword is "secret": cipher alphabet secrtabdfg...z
   stim_row_type directed_rows [0:22] = '{
      '{ModeEncrypt, "a",   1'b1, "s"},
      '{ModeEncrypt, "z",   1'b1, "z"},
      '{ModeEncrypt, "e",   1'b1, "t"},
      '{ModeEncrypt, "y",   1'b1, "y"},
      '{ModeEncrypt, "c",   1'b1, "c"},
      '{ModeEncrypt, "m",   1'b0, 8'h00},
      '{ModeEncrypt, 8'h00, 1'b1, 8'h00},
      '{ModeEncrypt, 8'hff, 1'b1, 8'h00},
      '{ModeEncrypt, "A",   1'b1, 8'h00},
      '{ModeEncrypt, "Z",   1'b1, 8'h00},
      '{ModeEncrypt, 8'h60, 1'b1, 8'h00},
      '{ModeEncrypt, 8'h7b, 1'b1, 8'h00},
      '{ModeEncrypt, 8'h80, 1'b1, 8'h00},
      '{ModeDecrypt, "s",   1'b1, "a"},
      '{ModeDecrypt, "a",   1'b1, "f"},
      '{ModeDecrypt, "z",   1'b1, "z"},
      '{ModeDecrypt, "t",   1'b1, "e"},
      '{ModeDecrypt, "q",   1'b0, 8'h00},
      '{ModeDecrypt, 8'h00, 1'b1, 8'h00},
      '{ModeDecrypt, 8'hff, 1'b1, 8'h00},
      '{ModeDecrypt, 8'h7b, 1'b1, 8'h00},
      '{ModeDecrypt, 8'h60, 1'b1, 8'h00},
      '{ModeDecrypt, "Z",   1'b1, 8'h00}
   };

   keyword_substitution_cipher u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_in_char      (req_in_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void rebuild_maps();
      logic [191:0]          key_bytes;
      logic [NumLetters-1:0] taken;
      letter_type            order [NumLetters];
      letter_type            idx;
      char_type              b;
      int                    fill;
      int                    span;
      key_bytes = {key_word_high, key_word_mid, key_word_low};
      span = (key_len > MaxKey) ? MaxKey : key_len;
      taken = '0;
      fill = 0;
      for (int p = 0; p < span; p++) begin
         b = key_bytes[p*8 +: 8];
         if (b >= CharLowerA && b <= CharLowerZ) begin
            idx = letter_type'(b - CharLowerA);
         end else if (b >= CharUpperA && b <= CharUpperZ) begin
            idx = letter_type'(b - CharUpperA);
         end else begin
            continue;
         end
         if (!taken[idx] && fill < NumLetters) begin
            taken[idx] = 1'b1;
            order[fill] = idx;
            fill++;
         end
      end
      for (int l = 0; l < NumLetters; l++) begin
         if (!taken[l]) begin
            taken[l] = 1'b1;
            order[fill] = letter_type'(l);
            fill++;
         end
      end
      for (int l = 0; l < NumLetters; l++) begin
         plain_to_cipher[l] = order[l];
         cipher_to_plain[order[l]] = letter_type'(l);
      end
   endfunction

   function automatic char_type substitute_char(input logic mode, input char_type ch);
      letter_type idx;
      if (ch < CharLowerA || ch > CharLowerZ) return 8'h00;
      idx = letter_type'(ch - CharLowerA);
      return CharLowerA + ((mode == ModeDecrypt) ? cipher_to_plain[idx] : plain_to_cipher[idx]);
   endfunction

   function automatic char_type pick_char();
      if ($urandom_range(3) != 0) return CharLowerA + char_type'($urandom_range(25));
      return char_type'($urandom_range(255));
   endfunction

   function automatic logic [63:0] random_key_word();
      logic [63:0] w;
      int          pick;
      for (int i = 0; i < 8; i++) begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            w[i*8 +: 8] = CharLowerA + char_type'($urandom_range(25));
         end else if (pick < 8) begin
            w[i*8 +: 8] = CharUpperA + char_type'($urandom_range(25));
         end else begin
            w[i*8 +: 8] = char_type'($urandom_range(255));
         end
      end
      return w;
   endfunction

   // called at a rising edge; returns at the edge that takes the transaction
   task automatic offer_char(input logic mode, input char_type ch, input bit known,
                             input char_type pinned);
      pinned_type entry;
      entry.known = known;
      entry.value = pinned;
      pinned_out_chars = {pinned_out_chars, entry};
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_in_char <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic random_chars(input int count);
      for (int n = 0; n < count; n++) begin
         offer_char(logic'($urandom_range(1)), pick_char(), 1'b0, 8'h00);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_out_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CsrKeyLow:    key_word_low  = data;
         CsrKeyMid:    key_word_mid  = data;
         CsrKeyHigh:   key_word_high = data;
         CsrKeyLength: key_len       = data[4:0];
         default: ;
      endcase
      rebuild_maps();
      // tables rebuild with the input stalled
      for (int n = 0; n < 4 && req_stall !== 1'b1; n++) @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] lo, input logic [63:0] mid,
                           input logic [63:0] hi, input logic [4:0] len);
      write_reg(CsrKeyLow, lo);
      write_reg(CsrKeyMid, mid);
      write_reg(CsrKeyHigh, hi);
      write_reg(CsrKeyLength, {59'd0, len});
   endtask

   // receiver: random stall, or a long hold-off when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // scoreboard: check the oldest expectation, then queue the new transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_out_chars.size() == 0) begin
               $error("out_char: unexpected transaction, expected none actual %h",
                      rsp_out_char);
               mismatch_count++;
            end else if (rsp_out_char !== pending_out_chars[0]) begin
               $error("out_char: expected %h actual %h", pending_out_chars[0], rsp_out_char);
               mismatch_count++;
               void'(pending_out_chars.pop_front());
            end else begin
               void'(pending_out_chars.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            pin = pinned_out_chars.pop_front();
            pending_out_chars = {pending_out_chars,
                                 pin.known ? pin.value :
                                 substitute_char(req_mode, req_in_char)};
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mode         <= ModeEncrypt;
      req_in_char      <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index        <= CsrKeyLow;
      csr_write_data   <= 64'd0;
      key_word_low  = 64'h0000_7465_7263_6573;
      key_word_mid  = 64'd0;
      key_word_high = 64'd0;
      key_len       = 5'd6;
      rebuild_maps();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 48;
      foreach (directed_rows[r]) begin
         offer_char(directed_rows[r].mode, directed_rows[r].in_char,
                    directed_rows[r].known, directed_rows[r].out_char);
      end
      random_chars(80);
      drain();

      // mixed case, high bytes, repeats, length above the maximum
      load_key({8'h7a, 8'hc1, "a", "R", 8'hf2, "B", "e", "Z"},
               {"s", "s", "S", 8'h20, "q", "Q", "0", "m"},
               random_key_word(), 5'd31);
      random_chars(70);
      drain();

      // empty keyword gives the identity
      write_reg(CsrKeyLength, 64'd0);
      random_chars(50);
      drain();

      send_idle_pct = 48;
      recv_idle_pct = 33;
      load_key('1, '1, '1, 5'd24);
      random_chars(50);
      drain();

      // "thequick", "brownfxj", "mpsvlazy", first character in the lowest byte
      load_key(64'h6b63_6975_7165_6874, 64'h6a78_666e_776f_7262,
               64'h797a_616c_7673_706d, 5'd24);
      random_chars(70);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_key(random_key_word(), random_key_word(), random_key_word(),
               5'($urandom_range(31)));
      hold_cycles <= HoldOffCycles;
      random_chars(80);
      drain();

      for (int k = 0; k < 3; k++) begin
         load_key(random_key_word(), random_key_word(), random_key_word(),
                  5'($urandom_range(31)));
         random_chars(60);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_out_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
